FILE: sv/abarq_pkg.sv
// ----------------------------------------------------------------------------
// abarq_pkg
// Shared types and constants for the alternating-bit ARQ endpoint: queue
// sizing, mode and destination codes, descriptor layout and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package abarq_pkg;

  // pending queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int MODE_W = 2;
  localparam int DEST_W = 2;
  localparam int TAG_W  = 16;
  localparam int SIZE_W = 12;

  // input item kinds
  localparam logic [MODE_W-1:0] MODE_APP_SEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NET_RX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT  = 2'd2;

  // result destinations
  localparam logic [DEST_W-1:0] DEST_NET    = 2'd0;
  localparam logic [DEST_W-1:0] DEST_APP    = 2'd1;
  localparam logic [DEST_W-1:0] DEST_REJECT = 2'd2;

  // result source select
  localparam int EMIT_W = 3;
  localparam logic [EMIT_W-1:0] EMIT_REJECT  = 3'd0;
  localparam logic [EMIT_W-1:0] EMIT_NEW     = 3'd1;
  localparam logic [EMIT_W-1:0] EMIT_DELIVER = 3'd2;
  localparam logic [EMIT_W-1:0] EMIT_ACK_NEW = 3'd3;
  localparam logic [EMIT_W-1:0] EMIT_ACK_DUP = 3'd4;
  localparam logic [EMIT_W-1:0] EMIT_QHEAD   = 3'd5;
  localparam logic [EMIT_W-1:0] EMIT_OUTST   = 3'd6;

  // packet descriptor as stored in the queue and outstanding slot
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              seq;
    logic              ack;
  } desc_t;

  // controller to datapath
  typedef struct packed {
    logic              load_in;
    logic              emit;
    logic [EMIT_W-1:0] emit_sel;
    logic              emit_last;
    logic              toggle_send;
    logic              toggle_ack;
    logic              load_outst_new;
    logic              clear_outst;
    logic              push;
    logic              pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              size_zero;
    logic              seq_new;
    logic              ack_match;
    logic              outst_valid;
    logic              queue_full;
    logic              queue_nonempty;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/alternating_bit_arq_endpoint.sv
// ----------------------------------------------------------------------------
// alternating_bit_arq_endpoint
// Stop-and-wait alternating-bit endpoint, sender and receiver in one block.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while the item is worked on. An application send, an ack, a duplicate or a
// timeout is decided in the EXEC state, then the block is idle again; new
// data also passes through S_SECOND, because it gives two results (delivery,
// then ack) and the result register shows one result per cycle. Results
// appear on out_* for exactly one cycle with out_valid high, in the cycle
// after they are decided, and out_last marks the final result of an item.
// The receiver cannot stall: every result is consumed in the cycle it is
// shown. Up to QUEUE_DEPTH sends wait in a RAM while a packet is
// outstanding; the queue head is read every cycle through the RAM's
// registered port, and the decision is made in the state after acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module alternating_bit_arq_endpoint (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [abarq_pkg::MODE_W-1:0] in_mode,
  input  wire logic [abarq_pkg::TAG_W-1:0]  in_payload_tag,
  input  wire logic [abarq_pkg::SIZE_W-1:0] in_payload_size,
  input  wire logic                         in_pkt_seq,
  input  wire logic                         in_pkt_ack,
  output logic                              out_valid,
  output logic      [abarq_pkg::DEST_W-1:0] out_dest,
  output logic      [abarq_pkg::TAG_W-1:0]  out_tag,
  output logic      [abarq_pkg::SIZE_W-1:0] out_size,
  output logic                              out_seq,
  output logic                              out_ack,
  output logic                              out_last
);

  abarq_pkg::cmd_t  cmd;
  abarq_pkg::stat_t st;

  // sequencing
  abarq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // protocol state and result register
  abarq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_mode         (in_mode),
    .in_payload_tag  (in_payload_tag),
    .in_payload_size (in_payload_size),
    .in_pkt_seq      (in_pkt_seq),
    .in_pkt_ack      (in_pkt_ack),
    .out_valid       (out_valid),
    .out_dest        (out_dest),
    .out_tag         (out_tag),
    .out_size        (out_size),
    .out_seq         (out_seq),
    .out_ack         (out_ack),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

FILE: sv/abarq_ram.sv
// ----------------------------------------------------------------------------
// abarq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module abarq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/abarq_ctrl.sv
// ----------------------------------------------------------------------------
// abarq_ctrl
// Controller for the ARQ endpoint: takes an item, decides what it does from
// the datapath status and sequences up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module abarq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire abarq_pkg::stat_t st,
  output logic                busy,
  output abarq_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (st.mode)
          abarq_pkg::MODE_APP_SEND: begin
            if (st.queue_full) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = abarq_pkg::EMIT_REJECT;
              cmd.emit_last = 1'b1;
            end else begin
              cmd.toggle_send = 1'b1;
              if (!st.outst_valid) begin
                cmd.load_outst_new = 1'b1;
                cmd.emit           = 1'b1;
                cmd.emit_sel       = abarq_pkg::EMIT_NEW;
                cmd.emit_last      = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end
          end
          abarq_pkg::MODE_NET_RX: begin
            if (!st.size_zero) begin
              if (st.seq_new) begin
                // deliver now, ack follows in the next cycle
                cmd.emit       = 1'b1;
                cmd.emit_sel   = abarq_pkg::EMIT_DELIVER;
                cmd.toggle_ack = 1'b1;
                state_nxt      = S_SECOND;
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = abarq_pkg::EMIT_ACK_DUP;
                cmd.emit_last = 1'b1;
              end
            end else if (st.outst_valid && st.ack_match) begin
              if (st.queue_nonempty) begin
                cmd.pop       = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_sel  = abarq_pkg::EMIT_QHEAD;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.clear_outst = 1'b1;
              end
            end
          end
          abarq_pkg::MODE_TIMEOUT: begin
            if (st.outst_valid) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = abarq_pkg::EMIT_OUTST;
              cmd.emit_last = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SECOND: begin
        cmd.emit      = 1'b1;
        cmd.emit_sel  = abarq_pkg::EMIT_ACK_NEW;
        cmd.emit_last = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/abarq_dp.sv
// ----------------------------------------------------------------------------
// abarq_dp
// Datapath for the ARQ endpoint: item latch, send and ack bits, outstanding
// slot, pending queue with its pointers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abarq_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire abarq_pkg::cmd_t                    cmd,
  output abarq_pkg::stat_t                        st,
  input  wire logic [abarq_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [abarq_pkg::TAG_W-1:0]        in_payload_tag,
  input  wire logic [abarq_pkg::SIZE_W-1:0]       in_payload_size,
  input  wire logic                               in_pkt_seq,
  input  wire logic                               in_pkt_ack,
  output logic                                    out_valid,
  output logic      [abarq_pkg::DEST_W-1:0]       out_dest,
  output logic      [abarq_pkg::TAG_W-1:0]        out_tag,
  output logic      [abarq_pkg::SIZE_W-1:0]       out_size,
  output logic                                    out_seq,
  output logic                                    out_ack,
  output logic                                    out_last
);

  localparam int QW = abarq_pkg::QPTR_W;
  localparam int CW = abarq_pkg::QCNT_W;

  // latched item
  logic [abarq_pkg::MODE_W-1:0] mode_r;
  logic [abarq_pkg::TAG_W-1:0]  tag_r;
  logic [abarq_pkg::SIZE_W-1:0] size_r;
  logic                         pseq_r;
  logic                         pack_r;

  // protocol state
  logic             send_bit_r;
  logic             recv_ack_r;
  logic             outst_valid_r;
  abarq_pkg::desc_t outst_r;
  logic [QW-1:0]    head_r;
  logic [QW-1:0]    tail_r;
  logic [CW-1:0]    count_r;

  // result register
  logic                         out_valid_r;
  logic [abarq_pkg::DEST_W-1:0] dest_r;
  logic                         last_r;
  abarq_pkg::desc_t             res_r;

  abarq_pkg::desc_t             new_desc;
  abarq_pkg::desc_t             qhead;
  abarq_pkg::desc_t             res_nxt;
  logic [abarq_pkg::DEST_W-1:0] dest_nxt;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      tag_r  <= in_payload_tag;
      size_r <= in_payload_size;
      pseq_r <= in_pkt_seq;
      pack_r <= in_pkt_ack;
    end
  end

  // descriptor stamped with the toggled send bit and current ack bit
  assign new_desc = '{tag: tag_r, size: size_r, seq: ~send_bit_r, ack: recv_ack_r};

  // pending queue storage, read port follows the head
  abarq_ram #(
    .WIDTH ($bits(abarq_pkg::desc_t)),
    .DEPTH (abarq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (new_desc),
    .raddr (head_r),
    .rdata (qhead)
  );

  // sequence bits, outstanding flag and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_bit_r    <= 1'b0;
      recv_ack_r    <= 1'b0;
      outst_valid_r <= 1'b0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
    end else begin
      if (cmd.toggle_send) begin
        send_bit_r <= ~send_bit_r;
      end
      if (cmd.toggle_ack) begin
        recv_ack_r <= ~recv_ack_r;
      end
      if (cmd.load_outst_new || cmd.pop) begin
        outst_valid_r <= 1'b1;
      end else if (cmd.clear_outst) begin
        outst_valid_r <= 1'b0;
      end
      if (cmd.push) begin
        tail_r  <= (tail_r == QW'(abarq_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r  <= (head_r == QW'(abarq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_r <= count_r - 1'b1;
      end
    end
  end

  // outstanding packet slot
  always_ff @(posedge clk) begin
    if (cmd.load_outst_new) begin
      outst_r <= new_desc;
    end else if (cmd.pop) begin
      outst_r <= qhead;
    end
  end

  // result select
  always_comb begin
    dest_nxt = abarq_pkg::DEST_NET;
    res_nxt  = '0;
    case (cmd.emit_sel)
      abarq_pkg::EMIT_REJECT: begin
        dest_nxt = abarq_pkg::DEST_REJECT;
        res_nxt  = '{tag: tag_r, size: size_r, seq: 1'b0, ack: 1'b0};
      end
      abarq_pkg::EMIT_NEW:     res_nxt = new_desc;
      abarq_pkg::EMIT_DELIVER: begin
        dest_nxt = abarq_pkg::DEST_APP;
        res_nxt  = '{tag: tag_r, size: size_r, seq: 1'b0, ack: 1'b0};
      end
      abarq_pkg::EMIT_ACK_NEW: res_nxt.ack = pseq_r;
      abarq_pkg::EMIT_ACK_DUP: res_nxt.ack = recv_ack_r;
      abarq_pkg::EMIT_QHEAD:   res_nxt = qhead;
      abarq_pkg::EMIT_OUTST:   res_nxt = outst_r;
      default: begin
      end
    endcase
  end

  // result register, strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dest_r <= dest_nxt;
      res_r  <= res_nxt;
      last_r <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dest  = dest_r;
  assign out_tag   = res_r.tag;
  assign out_size  = res_r.size;
  assign out_seq   = res_r.seq;
  assign out_ack   = res_r.ack;
  assign out_last  = last_r;

  // status to the controller
  assign st.mode           = mode_r;
  assign st.size_zero      = (size_r == '0);
  assign st.seq_new        = (pseq_r != recv_ack_r);
  assign st.ack_match      = (pack_r == outst_r.seq);
  assign st.outst_valid    = outst_valid_r;
  assign st.queue_full     = outst_valid_r && (count_r == CW'(abarq_pkg::QUEUE_DEPTH));
  assign st.queue_nonempty = (count_r != '0);

`ifndef SYNTH
  // queue never overfills
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(abarq_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // items only wait while a packet is outstanding
  a_queue_needs_outst: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> outst_valid_r)
    else $error("queued items with nothing outstanding");

  // a pop takes one entry and keeps the slot valid
  a_pop_effect: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> ##1 (count_r == $past(count_r) - 1'b1) && outst_valid_r)
    else $error("pop did not advance queue");

  // a push never targets a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r != CW'(abarq_pkg::QUEUE_DEPTH)))
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

FILE: tb/alternating_bit_arq_endpoint_tb.sv
// ----------------------------------------------------------------------------
// alternating_bit_arq_endpoint_tb
// Self-checking bench for the stop-and-wait alternating-bit endpoint. A
// directed opening covers the corner cases: idle timeout, unused mode, stray
// and mismatched acks, new and duplicate data, and the pending queue filling
// up to a rejected send. It is followed by random traffic. The traffic runs
// in alternating fill and drain phases, so the queue both overflows and
// empties. Each accepted item goes through a behavioral copy of the
// endpoint, and every result strobe is checked against the oldest predicted
// result.
// ----------------------------------------------------------------------------

module alternating_bit_arq_endpoint_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abarq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_GAP      = 17;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 40;

  // one predicted or observed result
  typedef struct {
    logic [DEST_W-1:0] dest;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              seq;
    logic              ack;
    logic              last;
  } arq_result_t;

  // behavioral copy of the endpoint plus the list of results still owed
  class arq_scoreboard;
    arq_result_t owed_q[$];
    desc_t       waiting_q[$];
    desc_t       in_flight;
    bit          in_flight_valid;
    bit          send_bit;
    bit          rx_ack_bit;
    int unsigned errors;

    function arq_result_t make_result(logic [DEST_W-1:0] dest, logic [TAG_W-1:0] tag,
                                      logic [SIZE_W-1:0] size, logic seq, logic ack);
      arq_result_t r;
      r.dest = dest;
      r.tag  = tag;
      r.size = size;
      r.seq  = seq;
      r.ack  = ack;
      r.last = 1'b0;
      return r;
    endfunction

    // update the endpoint copy with an accepted item and queue its results
    function void note_item(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                            logic [SIZE_W-1:0] size, logic seq, logic ack);
      arq_result_t produced[$];
      desc_t d;
      case (mode)
        MODE_APP_SEND: begin
          if (in_flight_valid && waiting_q.size() >= QUEUE_DEPTH) begin
            produced.push_back(make_result(DEST_REJECT, tag, size, 1'b0, 1'b0));
          end else begin
            send_bit ^= 1'b1;
            d.tag  = tag;
            d.size = size;
            d.seq  = send_bit;
            d.ack  = rx_ack_bit;
            if (!in_flight_valid) begin
              in_flight       = d;
              in_flight_valid = 1'b1;
              produced.push_back(make_result(DEST_NET, d.tag, d.size, d.seq, d.ack));
            end else begin
              waiting_q.push_back(d);
            end
          end
        end
        MODE_NET_RX: begin
          if (size != '0) begin
            // data packet: deliver if new, always answer with an ack
            if (seq != rx_ack_bit) begin
              produced.push_back(make_result(DEST_APP, tag, size, 1'b0, 1'b0));
              rx_ack_bit ^= 1'b1;
              produced.push_back(make_result(DEST_NET, '0, '0, 1'b0, seq));
            end else begin
              produced.push_back(make_result(DEST_NET, '0, '0, 1'b0, rx_ack_bit));
            end
          end else if (in_flight_valid && ack == in_flight.seq) begin
            // matching ack frees the slot and launches the queue head
            in_flight_valid = 1'b0;
            if (waiting_q.size() > 0) begin
              in_flight       = waiting_q.pop_front();
              in_flight_valid = 1'b1;
              produced.push_back(make_result(DEST_NET, in_flight.tag, in_flight.size,
                                             in_flight.seq, in_flight.ack));
            end
          end
        end
        MODE_TIMEOUT: begin
          if (in_flight_valid)
            produced.push_back(make_result(DEST_NET, in_flight.tag, in_flight.size,
                                           in_flight.seq, in_flight.ack));
        end
        default: begin
        end
      endcase
      if (produced.size() > 0)
        produced[produced.size()-1].last = 1'b1;
      foreach (produced[i])
        owed_q.push_back(produced[i]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // compare one observed result with the oldest owed one
    function void check_result(arq_result_t got);
      arq_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual dest %0d tag 0x%0h size %0d",
                   $time, got.dest, got.tag, got.size);
        return;
      end
      want = owed_q.pop_front();
      compare_field("out_dest", want.dest, got.dest);
      compare_field("out_tag", want.tag, got.tag);
      compare_field("out_size", want.size, got.size);
      compare_field("out_seq", want.seq, got.seq);
      compare_field("out_ack", want.ack, got.ack);
      compare_field("out_last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [TAG_W-1:0]  in_payload_tag = '0;
  logic [SIZE_W-1:0] in_payload_size = '0;
  logic in_pkt_seq = 1'b0;
  logic in_pkt_ack = 1'b0;
  logic out_valid;
  logic [DEST_W-1:0] out_dest;
  logic [TAG_W-1:0]  out_tag;
  logic [SIZE_W-1:0] out_size;
  logic out_seq;
  logic out_ack;
  logic out_last;

  arq_scoreboard sb = new();
  int unsigned cycle_count = 0;

  alternating_bit_arq_endpoint i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_payload_tag  (in_payload_tag),
    .in_payload_size (in_payload_size),
    .in_pkt_seq      (in_pkt_seq),
    .in_pkt_ack      (in_pkt_ack),
    .out_valid       (out_valid),
    .out_dest        (out_dest),
    .out_tag         (out_tag),
    .out_size        (out_size),
    .out_seq         (out_seq),
    .out_ack         (out_ack),
    .out_last        (out_last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor, values sampled before the edge updates them
  always @(posedge clk) begin
    arq_result_t got;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        got.dest = out_dest;
        got.tag  = out_tag;
        got.size = out_size;
        got.seq  = out_seq;
        got.ack  = out_ack;
        got.last = out_last;
        sb.check_result(got);
      end else if (out_valid !== 1'b0) begin
        sb.errors++;
        $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
      end
    end
  end

  // present one item after an idle gap and hold it until the block takes it
  task automatic drive_item(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                            input logic [SIZE_W-1:0] size, input logic seq,
                            input logic ack, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_payload_tag  <= tag;
    in_payload_size <= size;
    in_pkt_seq      <= seq;
    in_pkt_ack      <= ack;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(mode, tag, size, seq, ack);
  endtask

  // corner cases, ending with the pending queue overflowing
  task automatic run_directed();
    drive_item(MODE_TIMEOUT, 16'h1234, 12'h001, 1'b0, 1'b0, $urandom_range(0, MAX_GAP));
    drive_item(MODE_UNUSED, 16'hFFFF, 12'hFFF, 1'b1, 1'b1, $urandom_range(0, MAX_GAP));
    drive_item(MODE_NET_RX, 16'h0000, 12'h000, 1'b0, 1'b0, $urandom_range(0, MAX_GAP));
    drive_item(MODE_APP_SEND, 16'hFFFF, 12'hFFF, 1'b0, 1'b0, $urandom_range(0, MAX_GAP));
    drive_item(MODE_TIMEOUT, 16'h0000, 12'h000, 1'b1, 1'b1, $urandom_range(0, MAX_GAP));
    // ack bit opposite to the outstanding seq
    drive_item(MODE_NET_RX, 16'hFFFF, 12'h000, 1'b1, 1'b0, $urandom_range(0, MAX_GAP));
    // new data, then the same again as a duplicate
    drive_item(MODE_NET_RX, 16'h0000, 12'h001, 1'b1, 1'b1, $urandom_range(0, MAX_GAP));
    drive_item(MODE_NET_RX, 16'hFFFF, 12'hFFF, 1'b1, 1'b0, $urandom_range(0, MAX_GAP));
    // fill the queue, the last send is rejected
    for (int k = 0; k <= QUEUE_DEPTH; k++)
      drive_item(MODE_APP_SEND, TAG_W'($urandom), (k == 0) ? 12'h000 : 12'($urandom),
                 1'($urandom), 1'($urandom), (k < 8) ? 0 : $urandom_range(0, MAX_GAP));
  endtask

  // mostly well-formed traffic, in fill and drain phases, with some noise
  task automatic run_random(input int n);
    int pick;
    int gap;
    bit fill;
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic seq;
    logic ack;
    for (int i = 0; i < n; i++) begin
      fill = ((i / 120) % 2) == 0;
      pick = $urandom_range(0, 99);
      mode = MODE_NET_RX;
      tag  = TAG_W'($urandom);
      size = SIZE_W'($urandom);
      seq  = 1'($urandom);
      ack  = 1'($urandom);
      if (pick < (fill ? 55 : 15)) begin
        mode = MODE_APP_SEND;
      end else if (pick < (fill ? 65 : 60)) begin
        // ack for the packet in flight
        size = '0;
        if (sb.in_flight_valid)
          ack = sb.in_flight.seq;
      end else if (pick < 82) begin
        // data, mostly new
        if (size == '0)
          size = 12'h001;
        seq = ($urandom_range(0, 3) == 0) ? sb.rx_ack_bit : ~sb.rx_ack_bit;
      end else if (pick < 90) begin
        mode = MODE_TIMEOUT;
      end else if (pick < 95) begin
        // ack with an arbitrary bit
        size = '0;
      end else begin
        mode = MODE_W'($urandom);
      end
      gap = ((i / 50) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
      drive_item(mode, tag, size, seq, ack, gap);
    end
  endtask

  // reset, stimulus, drain and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_ITEMS);
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
